### rtl/rgbbd_pkg.sv
package rgbbd_pkg;

  // Default width of the two millisecond counters
  localparam int unsigned TimerBitsDef = 32;

  // Command codes
  typedef enum logic [2:0] {
    CMD_TICK           = 3'd0,
    CMD_SET_COLOUR     = 3'd1,
    CMD_PALETTE        = 3'd2,
    CMD_SET_BRIGHTNESS = 3'd3,
    CMD_START_BLINK    = 3'd4,
    CMD_STOP_BLINK     = 3'd5,
    CMD_OFF            = 3'd6
  } cmd_e;

  // Palette indexes
  typedef enum logic [2:0] {
    PAL_OFF     = 3'd0,
    PAL_RED     = 3'd1,
    PAL_GREEN   = 3'd2,
    PAL_BLUE    = 3'd3,
    PAL_YELLOW  = 3'd4,
    PAL_ORANGE  = 3'd5,
    PAL_MAGENTA = 3'd6
  } pal_e;

  // Decoded command for one transfer
  typedef struct packed {
    logic tick;
    logic load_col;
    logic load_bri;
    logic start;
    logic stop;
  } ctl_t;

  // What a tick leaves for the pixel path
  typedef struct packed {
    logic emit;
    logic show;
  } tick_res_t;

  // Palette entry as {red, green, blue}
  function automatic logic [23:0] palette(input logic [2:0] idx);
    logic [23:0] rgb;
    case (pal_e'(idx))
      PAL_RED:     rgb = {8'd255, 8'd0,   8'd0};
      PAL_GREEN:   rgb = {8'd0,   8'd255, 8'd0};
      PAL_BLUE:    rgb = {8'd0,   8'd0,   8'd255};
      PAL_YELLOW:  rgb = {8'd255, 8'd255, 8'd0};
      PAL_ORANGE:  rgb = {8'd255, 8'd120, 8'd0};
      PAL_MAGENTA: rgb = {8'd255, 8'd0,   8'd255};
      default:     rgb = 24'd0;
    endcase
    return rgb;
  endfunction

  // floor(v * b / 255); exact for any product of two 8-bit values
  function automatic logic [7:0] scale255(input logic [7:0] v, input logic [7:0] b);
    logic [15:0] p;
    logic [15:0] s;
    p = 16'(v) * 16'(b);
    s = p + (p >> 8) + 16'd1;
    return s[15:8];
  endfunction

endpackage

### rtl/rgbbd_colour.sv
module rgbbd_colour
  import rgbbd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  ctl_t        ctl_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic [7:0]  level_i,
  output logic [23:0] grb_o
);

  logic [7:0] red_q, green_q, blue_q, bri_q;
  logic [7:0] red_d, green_d, blue_d, bri_d;

  // Stored colour and brightness
  always_comb begin
    red_d   = red_q;
    green_d = green_q;
    blue_d  = blue_q;
    bri_d   = bri_q;
    if (step_i && ctl_i.load_col) begin
      red_d   = red_i;
      green_d = green_i;
      blue_d  = blue_i;
      bri_d   = level_i;
    end else if (step_i && ctl_i.load_bri) begin
      bri_d = level_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_q   <= 8'd0;
      green_q <= 8'd0;
      blue_q  <= 8'd0;
      bri_q   <= 8'd255;
    end else begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
      bri_q   <= bri_d;
    end
  end

  // Scaled pixel from the updated colour, GRB order
  assign grb_o = {scale255(green_d, bri_d), scale255(red_d, bri_d), scale255(blue_d, bri_d)};

endmodule

### rtl/rgbbd_blink.sv
module rgbbd_blink
  import rgbbd_pkg::*;
#(
  parameter int unsigned TIMER_BITS = TimerBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  ctl_t        ctl_i,
  input  logic [31:0] interval_i,
  input  logic [31:0] duration_i,
  output logic        blinking_o,
  output tick_res_t   tick_o
);

  localparam int unsigned CmpW = (TIMER_BITS > 32) ? TIMER_BITS : 32;

  logic                  blinking_q, blinking_d;
  logic                  phase_q, phase_d;
  logic [31:0]           half_q, half_d;
  logic [31:0]           limit_q, limit_d;
  logic [TIMER_BITS-1:0] tog_q, tog_d, tog_inc;
  logic [TIMER_BITS-1:0] run_q, run_d, run_inc;
  logic                  limit_hit, toggle_due;

  // Saturating counters and their thresholds
  assign tog_inc    = (&tog_q) ? tog_q : tog_q + TIMER_BITS'(1);
  assign run_inc    = (&run_q) ? run_q : run_q + TIMER_BITS'(1);
  assign limit_hit  = (limit_q != 32'd0) && (CmpW'(run_inc) >= CmpW'(limit_q));
  assign toggle_due = CmpW'(tog_inc) >= CmpW'(half_q);

  // Next state
  always_comb begin
    blinking_d = blinking_q;
    phase_d    = phase_q;
    half_d     = half_q;
    limit_d    = limit_q;
    tog_d      = tog_q;
    run_d      = run_q;
    if (step_i) begin
      if (ctl_i.tick && blinking_q) begin
        tog_d = tog_inc;
        run_d = run_inc;
        if (limit_hit) begin
          blinking_d = 1'b0;
          limit_d    = 32'd0;
        end else if (toggle_due) begin
          phase_d = !phase_q;
          tog_d   = '0;
        end
      end else if (ctl_i.start) begin
        half_d     = interval_i;
        limit_d    = duration_i;
        blinking_d = 1'b1;
        phase_d    = 1'b1;
        tog_d      = '0;
        run_d      = '0;
      end else if (ctl_i.stop) begin
        blinking_d = 1'b0;
        limit_d    = 32'd0;
      end
    end
  end

  // Tick outcome for the pixel path
  always_comb begin
    tick_o.emit = blinking_q && (limit_hit || toggle_due);
    tick_o.show = !limit_hit && !phase_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blinking_q <= 1'b0;
      phase_q    <= 1'b1;
      half_q     <= 32'd0;
      limit_q    <= 32'd0;
      tog_q      <= '0;
      run_q      <= '0;
    end else begin
      blinking_q <= blinking_d;
      phase_q    <= phase_d;
      half_q     <= half_d;
      limit_q    <= limit_d;
      tog_q      <= tog_d;
      run_q      <= run_d;
    end
  end

  assign blinking_o = blinking_q;

endmodule

### rtl/rgb_led_blink_brightness_driver_core.sv
// Channel   Handshake                  Payload
// input     in_valid_i / in_ready_o    command, red, green, blue, level, color_index,
//                                      interval, duration
// output    out_valid_o / out_ready_i  grb_word
//
// One command per cycle while the output is not stalled; a pixel is offered
// after its command passes the input register and then the result register.
// Colour scaling and the blink counters update in the single stage between
// those registers.
// Reset: colour black, brightness full, blink idle, no pending result.
// A stalled output holds the result; the input register keeps one command
// waiting, so in_ready_o drops only when both registers are full and stalled.
module rgb_led_blink_brightness_driver_core
  import rgbbd_pkg::*;
#(
  parameter int unsigned TIMER_BITS = TimerBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  command_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic [7:0]  level_i,
  input  logic [2:0]  color_index_i,
  input  logic [31:0] interval_i,
  input  logic [31:0] duration_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [23:0] grb_word_o
);

  logic        in_valid_q;
  logic [2:0]  cmd_q, idx_q;
  logic [7:0]  red_q, green_q, blue_q, level_q;
  logic [31:0] interval_q, duration_q;
  logic        out_valid_q;
  logic [23:0] grb_q;

  logic        advance, step;
  ctl_t        ctl;
  logic [7:0]  new_red, new_green, new_blue, new_level;
  logic [23:0] pal_rgb, scaled;
  logic        blinking;
  tick_res_t   tick_res;
  logic        emit, show;

  // Pipeline flow
  assign advance    = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q      <= command_i;
      idx_q      <= color_index_i;
      red_q      <= red_i;
      green_q    <= green_i;
      blue_q     <= blue_i;
      level_q    <= level_i;
      interval_q <= interval_i;
      duration_q <= duration_i;
    end
  end

  // Command decode; an unused palette index or command does nothing
  assign pal_rgb = palette(idx_q);

  always_comb begin
    ctl       = '0;
    new_red   = red_q;
    new_green = green_q;
    new_blue  = blue_q;
    new_level = level_q;
    case (cmd_e'(cmd_q))
      CMD_TICK:           ctl.tick = 1'b1;
      CMD_SET_COLOUR:     ctl.load_col = 1'b1;
      CMD_PALETTE: begin
        ctl.load_col = (idx_q <= PAL_MAGENTA);
        new_red      = pal_rgb[23:16];
        new_green    = pal_rgb[15:8];
        new_blue     = pal_rgb[7:0];
        if (idx_q == PAL_OFF) begin
          new_level = 8'd0;
        end
      end
      CMD_SET_BRIGHTNESS: ctl.load_bri = 1'b1;
      CMD_START_BLINK:    ctl.start = 1'b1;
      CMD_STOP_BLINK,
      CMD_OFF:            ctl.stop = 1'b1;
      default:            ctl = '0;
    endcase
  end

  rgbbd_colour u_colour (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .ctl_i   (ctl),
    .red_i   (new_red),
    .green_i (new_green),
    .blue_i  (new_blue),
    .level_i (new_level),
    .grb_o   (scaled)
  );

  rgbbd_blink #(
    .TIMER_BITS (TIMER_BITS)
  ) u_blink (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .ctl_i      (ctl),
    .interval_i (interval_q),
    .duration_i (duration_q),
    .blinking_o (blinking),
    .tick_o     (tick_res)
  );

  // Result selection
  always_comb begin
    emit = 1'b0;
    show = 1'b0;
    if (ctl.tick) begin
      emit = tick_res.emit;
      show = tick_res.show;
    end else if (ctl.load_col || ctl.load_bri) begin
      emit = !blinking;
      show = 1'b1;
    end else if (ctl.start) begin
      emit = 1'b1;
      show = 1'b1;
    end else if (ctl.stop) begin
      emit = 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= emit;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      grb_q <= show ? scaled : 24'd0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign grb_word_o  = grb_q;

  // Blink ending always leaves a black pixel behind
  a_stop_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(blinking) |-> out_valid_q && (grb_q == 24'd0))
    else $error("blink ended without a black pixel");

  // A held command is not lost while the output stalls
  a_hold_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q)
    else $error("pending command dropped");

  // Start blink arms the blink controller and shows the colour
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && ctl.start |=> blinking && out_valid_q)
    else $error("start blink not taken");

endmodule
